[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge out of reset
`define CHK_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rlf_pkg.sv]
// shared types, constants and helper functions for the rgbw fade engine
`default_nettype none

package rlf_pkg;

  // default parameter values
  localparam int PRESET_COUNT_DEF    = 8;
  localparam int DUTY_FULL_SCALE_DEF = 100;

  // field widths
  localparam int NUM_CH = 4;
  localparam int CMD_W  = 2;
  localparam int SLOT_W = 3;
  localparam int DUTY_W = 7;
  localparam int FADE_W = 7;
  localparam int TICK_W = 7;
  localparam int STEP_W = 8;
  localparam int PROD_W = 14;

  // fade scale and its reciprocal for the step divide
  localparam int FADE_SCALE  = 100;
  localparam int RECIP_100   = 1311;
  localparam int RECIP_SHIFT = 17;
  localparam int SCALE_W     = 25;

  // channel positions
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;
  localparam int CH_WHITE = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_LOAD,
    ST_MUL,
    ST_SCALE,
    ST_FIX,
    ST_TICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [NUM_CH-1:0][DUTY_W-1:0] target;
    logic [FADE_W-1:0]             fade;
  } preset_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic write_preset;
    logic mem_read;
    logic load_fade;
    logic mul;
    logic scale;
    logic fix;
    logic tick;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t op;
    logic slot_ok;
    logic fade_zero;
    logic last_ch;
  } dp_status_t;

  // number of ticks for a fade percent: FADE_SCALE / f, zero for f == 0
  function automatic logic [TICK_W-1:0] tick_count(input logic [FADE_W-1:0] f);
    logic [TICK_W-1:0] t;
    priority if (f >= 7'd51) t = 7'd1;
    else if (f >= 7'd34) t = 7'd2;
    else if (f >= 7'd26) t = 7'd3;
    else if (f >= 7'd21) t = 7'd4;
    else if (f >= 7'd17) t = 7'd5;
    else if (f >= 7'd15) t = 7'd6;
    else if (f >= 7'd13) t = 7'd7;
    else if (f == 7'd12) t = 7'd8;
    else if (f == 7'd11) t = 7'd9;
    else if (f == 7'd10) t = 7'd10;
    else if (f == 7'd9)  t = 7'd11;
    else if (f == 7'd8)  t = 7'd12;
    else if (f == 7'd7)  t = 7'd14;
    else if (f == 7'd6)  t = 7'd16;
    else if (f == 7'd5)  t = 7'd20;
    else if (f == 7'd4)  t = 7'd25;
    else if (f == 7'd3)  t = 7'd33;
    else if (f == 7'd2)  t = 7'd50;
    else if (f == 7'd1)  t = 7'd100;
    else                 t = 7'd0;
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/rlf_ctrl.sv]
// controller state machine sequencing the fade datapath
`default_nettype none
`include "assert_macros.svh"

module rlf_ctrl import rlf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.op)
          CMD_WRITE: begin
            cmd.write_preset = 1'b1;
            state_nxt        = ST_EMIT;
          end
          CMD_START: begin
            if (status.slot_ok) begin
              cmd.mem_read = 1'b1;
              state_nxt    = ST_LOAD;
            end else begin
              state_nxt = ST_EMIT;
            end
          end
          CMD_TICK: state_nxt = ST_TICK;
          CMD_NONE: state_nxt = ST_EMIT;
        endcase
      end
      ST_LOAD: begin
        cmd.load_fade = 1'b1;
        state_nxt     = status.fade_zero ? ST_EMIT : ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = ST_FIX;
      end
      ST_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = status.last_ch ? ST_EMIT : ST_MUL;
      end
      ST_TICK: begin
        cmd.tick  = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // result beat held until taken, reloaded on emit
  assign out_valid_nxt = (out_valid_r && out_stall) || cmd.emit;
  assign out_valid     = out_valid_r;
  assign in_stall      = (state_r != ST_IDLE);

  `CHK_NEXT(accept_to_decode, in_valid && !in_stall, state_r == ST_DECODE, "accept did not decode")
  `CHK_IMPLY(emit_slot_free, cmd.emit, !out_valid_r || !out_stall, "result overwritten")
  `CHK_NEXT(emit_sets_valid, cmd.emit, out_valid_r && state_r == ST_IDLE, "emit lost")

endmodule

`default_nettype wire

[rtl/rlf_datapath.sv]
// preset memory, channel duty state, step arithmetic and result register
`default_nettype none
`include "assert_macros.svh"

module rlf_datapath import rlf_pkg::*; #(
  parameter int PRESET_COUNT    = PRESET_COUNT_DEF,
  parameter int DUTY_FULL_SCALE = DUTY_FULL_SCALE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_status_t                    status,
  input  logic [CMD_W-1:0]              in_cmd,
  input  logic [SLOT_W-1:0]             in_preset_slot,
  input  logic [NUM_CH-1:0][DUTY_W-1:0] in_target,
  input  logic [FADE_W-1:0]             in_fade_percent,
  output logic [NUM_CH-1:0][DUTY_W-1:0] out_duty,
  output logic                          out_fading,
  output logic [TICK_W-1:0]             out_ticks_left
);

  localparam int          PIDX_W = (PRESET_COUNT > 1) ? $clog2(PRESET_COUNT) : 1;
  localparam logic [7:0]  FS     = 8'(DUTY_FULL_SCALE);
  localparam logic [6:0]  PCNT   = 7'(PRESET_COUNT);

  // captured item
  cmd_t                          op_r;
  logic [SLOT_W-1:0]             slot_r;
  logic [NUM_CH-1:0][DUTY_W-1:0] tgt_in_r;
  logic [FADE_W-1:0]             fade_in_r;

  // preset memory with per-entry valid bits
  preset_t                       mem_r [PRESET_COUNT];
  logic [PRESET_COUNT-1:0]       valid_r;
  preset_t                       rd_data_r;
  logic                          rd_valid_r;
  preset_t                       entry;
  preset_t                       wr_entry;

  // channel state
  logic [NUM_CH-1:0][DUTY_W-1:0] duty_r;
  logic [NUM_CH-1:0][STEP_W-1:0] step_r;
  logic [NUM_CH-1:0][DUTY_W-1:0] target_r;
  logic [TICK_W-1:0]             ticks_r;

  // step computation
  logic [FADE_W-1:0]             fade_r;
  logic [1:0]                    ch_r;
  logic [PROD_W-1:0]             prod_r;
  logic                          neg_r;
  logic [STEP_W-1:0]             scaled_r;

  // result register
  logic [NUM_CH-1:0][DUTY_W-1:0] out_duty_r;
  logic [TICK_W-1:0]             out_ticks_r;

  logic [6:0]                    slot_ext;
  logic [PIDX_W-1:0]             idx;
  logic signed [STEP_W-1:0]      diff;
  logic [DUTY_W-1:0]             dist_mag;
  logic [SCALE_W-1:0]            scale_prod;
  logic [PROD_W:0]               back_prod;
  logic [STEP_W-1:0]             quot;
  logic [STEP_W-1:0]             step_val;
  logic signed [8:0]             tick_sum  [NUM_CH];
  logic [DUTY_W-1:0]             tick_duty [NUM_CH];
  logic                          duty_ok;

  // slot decode
  assign slot_ext = 7'(slot_r);
  assign idx      = slot_ext[PIDX_W-1:0];

  assign status.op        = op_r;
  assign status.slot_ok   = (slot_ext < PCNT);
  assign status.fade_zero = (entry.fade == '0);
  assign status.last_ch   = (ch_r == 2'(NUM_CH - 1));

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= cmd_t'(in_cmd);
      slot_r    <= in_preset_slot;
      tgt_in_r  <= in_target;
      fade_in_r <= in_fade_percent;
    end
  end

  // preset write value with clamps
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      wr_entry.target[c] = ({1'b0, tgt_in_r[c]} > FS) ? FS[DUTY_W-1:0] : tgt_in_r[c];
    end
    wr_entry.fade = (fade_in_r > 7'(FADE_SCALE)) ? 7'(FADE_SCALE) : fade_in_r;
  end

  // preset memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_preset && status.slot_ok) begin
      mem_r[idx] <= wr_entry;
    end
    if (cmd.mem_read) begin
      rd_data_r <= mem_r[idx];
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.write_preset && status.slot_ok) begin
        valid_r[idx] <= 1'b1;
      end
      if (cmd.mem_read) begin
        rd_valid_r <= valid_r[idx];
      end
    end
  end

  assign entry = rd_valid_r ? rd_data_r : '0;

  // distance magnitude of the channel in work
  assign diff     = $signed({1'b0, target_r[ch_r]}) - $signed({1'b0, duty_r[ch_r]});
  assign dist_mag = diff[STEP_W-1] ? DUTY_W'(-diff) : DUTY_W'(diff);

  // divide by the fade scale: reciprocal multiply, then one correction
  assign scale_prod = {11'd0, prod_r} * SCALE_W'(RECIP_100);
  assign back_prod  = 15'({7'd0, scaled_r} * 15'(FADE_SCALE));
  assign quot       = (back_prod > {1'b0, prod_r}) ? scaled_r - 8'd1 : scaled_r;
  assign step_val   = neg_r ? -quot : quot;

  // fade tick per channel: add step, clamp to zero and to full scale
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      tick_sum[c] = $signed({2'b00, duty_r[c]}) + $signed({step_r[c][STEP_W-1], step_r[c]});
      if (tick_sum[c][8]) begin
        tick_duty[c] = '0;
      end else if (tick_sum[c][7:0] > FS) begin
        tick_duty[c] = FS[DUTY_W-1:0];
      end else begin
        tick_duty[c] = tick_sum[c][DUTY_W-1:0];
      end
    end
  end

  // step pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= PROD_W'({7'd0, dist_mag} * {7'd0, fade_r});
      neg_r  <= diff[STEP_W-1];
    end
    if (cmd.scale) begin
      scaled_r <= scale_prod[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
    end
    if (cmd.load_fade) begin
      fade_r <= entry.fade;
    end
  end

  // channel counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_r <= '0;
    end else if (cmd.load_fade) begin
      ch_r <= '0;
    end else if (cmd.fix) begin
      ch_r <= ch_r + 2'd1;
    end
  end

  // channel duty, step, target and tick count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r   <= '0;
      step_r   <= '0;
      target_r <= '0;
      ticks_r  <= '0;
    end else begin
      if (cmd.load_fade) begin
        target_r <= entry.target;
        if (entry.fade == '0) begin
          duty_r  <= entry.target;
          step_r  <= '0;
          ticks_r <= '0;
        end else begin
          ticks_r <= tick_count(entry.fade);
        end
      end
      if (cmd.fix) begin
        step_r[ch_r] <= step_val;
      end
      if (cmd.tick && ticks_r != '0) begin
        ticks_r <= ticks_r - 7'd1;
        for (int c = 0; c < NUM_CH; c++) begin
          duty_r[c] <= (ticks_r == 7'd1) ? target_r[c] : tick_duty[c];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_duty_r  <= duty_r;
      out_ticks_r <= ticks_r;
    end
  end

  assign out_duty       = out_duty_r;
  assign out_ticks_left = out_ticks_r;
  assign out_fading     = (out_ticks_r != '0);

  // all duties within full scale
  assign duty_ok = ({1'b0, duty_r[CH_RED]} <= FS) && ({1'b0, duty_r[CH_GREEN]} <= FS) &&
                   ({1'b0, duty_r[CH_BLUE]} <= FS) && ({1'b0, duty_r[CH_WHITE]} <= FS);

  `CHK_ALWAYS(ticks_in_range, ticks_r <= 7'(FADE_SCALE), "tick count above fade scale")
  `CHK_ALWAYS(duty_in_range, duty_ok, "duty above full scale")
  `CHK_IMPLY(fix_in_fade, cmd.fix, fade_r != '0 && ticks_r != '0, "step computed without a fade")

endmodule

`default_nettype wire

[rtl/rgbw_linear_fade_engine.sv]
// top level of the rgbw linear fade engine
//
// Usage: one input channel (in_valid / in_stall) carries a command beat with
// cmd, preset_slot, four targets and a fade percent. Every accepted beat gives
// exactly one result beat on the output channel (out_valid / out_stall) with
// the four channel duties, the fading flag and the remaining tick count.
// Command 0 writes a preset, 1 starts a fade to a preset, 2 is one fade tick,
// 3 does nothing and reports the current state.
// Sequence: a preset write, an idle command or an out-of-range slot goes
// from decode straight to emit, a tick through the tick state and a
// zero-fade start through the load state; a fade start loads, then computes
// the four channel steps one after another through a shared multiply,
// reciprocal scale and correction sequence. One item is in work at a time:
// the next beat is accepted only after the result of the last is emitted.
// A finished result waits in the output register while the next beat is
// accepted; a stalled receiver holds the block only once a second result is
// ready. Synchronous active-low reset clears all duties, steps, targets, the
// tick count and every preset valid bit (presets read as zero until written).
`default_nettype none

module rgbw_linear_fade_engine import rlf_pkg::*; #(
  parameter int PRESET_COUNT    = PRESET_COUNT_DEF,
  parameter int DUTY_FULL_SCALE = DUTY_FULL_SCALE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [SLOT_W-1:0] in_preset_slot,
  input  logic [DUTY_W-1:0] in_target_red,
  input  logic [DUTY_W-1:0] in_target_green,
  input  logic [DUTY_W-1:0] in_target_blue,
  input  logic [DUTY_W-1:0] in_target_white,
  input  logic [FADE_W-1:0] in_fade_percent,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DUTY_W-1:0] out_duty_red,
  output logic [DUTY_W-1:0] out_duty_green,
  output logic [DUTY_W-1:0] out_duty_blue,
  output logic [DUTY_W-1:0] out_duty_white,
  output logic              out_fading,
  output logic [TICK_W-1:0] out_ticks_left
);

  dp_cmd_t                       cmd;
  dp_status_t                    status;
  logic [NUM_CH-1:0][DUTY_W-1:0] in_target;
  logic [NUM_CH-1:0][DUTY_W-1:0] out_duty;

  // channel bundling
  assign in_target[CH_RED]   = in_target_red;
  assign in_target[CH_GREEN] = in_target_green;
  assign in_target[CH_BLUE]  = in_target_blue;
  assign in_target[CH_WHITE] = in_target_white;

  assign out_duty_red   = out_duty[CH_RED];
  assign out_duty_green = out_duty[CH_GREEN];
  assign out_duty_blue  = out_duty[CH_BLUE];
  assign out_duty_white = out_duty[CH_WHITE];

  // sequencer
  rlf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  rlf_datapath #(
    .PRESET_COUNT    (PRESET_COUNT),
    .DUTY_FULL_SCALE (DUTY_FULL_SCALE)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_cmd          (in_cmd),
    .in_preset_slot  (in_preset_slot),
    .in_target       (in_target),
    .in_fade_percent (in_fade_percent),
    .out_duty        (out_duty),
    .out_fading      (out_fading),
    .out_ticks_left  (out_ticks_left)
  );

endmodule

`default_nettype wire
